// ===== hw/rtl/text_console_char_writer_assert.svh =====
// assertion macros for the text console character writer
// no dependencies; expects clk and rst_n in the including scope
`ifndef TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH

`ifndef SYNTH
`define TCW_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcw assertion failed");
`define TCW_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcw assertion failed");
`else
`define TCW_ASSERT_IMP(label, ante, cons)
`define TCW_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/tcw_pkg.sv =====
// shared constants, types and helpers for the text console character writer
// no dependencies
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_STOP   = 8;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_END   = CELL_COUNT - COLUMNS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BLANK = 8'h20;

  localparam logic [7:0] ATTR_RESET = 8'h07;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             scroll;
    logic             wr;
  } cur_upd_t;

  function automatic logic [ADDR_W-1:0] lin_pos(input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] col);
    lin_pos = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

// ===== hw/rtl/tcw_if.sv =====
// handshake channel interfaces: input item, result item and attribute write
// depends on tcw_pkg
`timescale 1ns / 1ps

interface tcw_in_if import tcw_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [7:0]        char_code;
  logic [ADDR_W-1:0] cell_index;

  modport source (output valid, action, char_code, cell_index, input ready);
  modport sink   (input valid, action, char_code, cell_index, output ready);
endinterface

interface tcw_out_if import tcw_pkg::*;;
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  cursor_column;
  logic [ROW_W-1:0]  cursor_row;
  logic [ADDR_W-1:0] cursor_position;
  logic              scrolled;
  logic [CELL_W-1:0] cell_data;

  modport source (output valid, cursor_column, cursor_row, cursor_position, scrolled,
                  cell_data, input ready);
  modport sink   (input valid, cursor_column, cursor_row, cursor_position, scrolled,
                  cell_data, output ready);
endinterface

interface tcw_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_attribute;

  modport source (output valid, text_attribute, input ready);
  modport sink   (input valid, text_attribute, output ready);
endinterface

// ===== hw/rtl/text_console_char_writer.sv =====
// Text console character writer: 80x25 cell store, cursor and a small sequencer
// that walks the store through one shared read port and write port.
// Channels: in_if (action, char_code, cell_index), out_if (cursor and cell data),
// cfg_if (text_attribute, always ready; user rule: written only while idle, not enforced).
// A transfer on in_if happens only while the sequencer is idle; each item gives
// exactly one result transfer on out_if.
// Steps from input transfer to result valid:
//   put character without scroll, unused action: S_DONE, then the output register
//   read cell: registered memory read, then S_DONE and the output register
//   put character that scrolls: 1920 cell copies from the row below, one turnaround, 80 blanks
//   clear screen: every cell blanked, one cell written per cycle
// The next item is taken the cycle after a result is loaded; the sequencer
// takes no new item before it is through with the last one.
// The cell store has a single port pair, which all these steps share.
// After reset every cell of the store is swept to zero; in_if is not ready
// meanwhile, cfg_if transfers are still taken.
// The result sits in an output register; if the receiver stalls, a finished
// item waits in the sequencer and no new item is taken until it moves on.
// depends on tcw_pkg, tcw_if, tcw_cursor and text_console_char_writer_assert.svh
`timescale 1ns / 1ps
`include "text_console_char_writer_assert.svh"

module text_console_char_writer import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tcw_in_if.sink    in_if,
  tcw_out_if.source out_if,
  tcw_cfg_if.sink   cfg_if
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_SCROLL = 5'b00100,
    S_FILL   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic [ADDR_W-1:0] wr_addr_r;
  logic              init_r, init_nxt;
  logic [CELL_W-1:0] fill_data_r, fill_data_nxt;
  logic [7:0]        attr_r;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic              res_scroll_r, res_scroll_nxt;
  logic [CELL_W-1:0] res_data_r, res_data_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [ADDR_W-1:0] out_pos_r;
  logic              out_scroll_r;
  logic [CELL_W-1:0] out_data_r;

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] mem_rdata_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;

  logic              in_fire, out_load;
  logic [CELL_W-1:0] blank;
  cur_upd_t          upd;

  tcw_cursor u_cursor (
    .col       (cur_col_r),
    .row       (cur_row_r),
    .char_code (in_if.char_code),
    .upd       (upd)
  );

  assign blank        = {attr_r, CH_BLANK};
  assign in_if.ready  = (state_r == S_IDLE);
  assign in_fire      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign out_load     = (state_r == S_DONE) && (!out_valid_r || out_if.ready);

  // shared memory port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r;
    mem_wdata = fill_data_r;
    mem_raddr = in_if.cell_index;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && action_t'(in_if.action) == ACT_PUT && upd.wr) begin
          mem_we    = 1'b1;
          mem_waddr = lin_pos(cur_row_r, cur_col_r);
          mem_wdata = {attr_r, in_if.char_code};
        end
      end
      S_SCROLL: begin
        mem_raddr = cnt_r + ADDR_W'(COLUMNS);
        if (wr_pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr_r;
          mem_wdata = mem_rdata_r;
        end else if (cnt_r >= ADDR_W'(COPY_END)) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_r;
          mem_wdata = blank;
        end
      end
      S_FILL: begin
        mem_we = 1'b1;
      end
      S_READ, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= mem[mem_raddr];
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    wr_pend_nxt    = 1'b0;
    init_nxt       = init_r;
    fill_data_nxt  = fill_data_r;
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    res_scroll_nxt = res_scroll_r;
    res_data_nxt   = res_data_r;
    rd_ok_nxt      = rd_ok_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_scroll_nxt = 1'b0;
          res_data_nxt   = '0;
          cnt_nxt        = '0;
          case (action_t'(in_if.action))
            ACT_PUT: begin
              cur_col_nxt    = upd.col;
              cur_row_nxt    = upd.row;
              res_scroll_nxt = upd.scroll;
              state_nxt      = upd.scroll ? S_SCROLL : S_DONE;
            end
            ACT_CLEAR: begin
              fill_data_nxt = blank;
              state_nxt     = S_FILL;
            end
            ACT_READ: begin
              rd_ok_nxt = (in_if.cell_index < ADDR_W'(CELL_COUNT));
              state_nxt = S_READ;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        res_data_nxt = rd_ok_r ? mem_rdata_r : '0;
        state_nxt    = S_DONE;
      end
      S_SCROLL: begin
        if (cnt_r < ADDR_W'(COPY_END)) begin
          wr_pend_nxt = 1'b1;
          cnt_nxt     = cnt_r + 1'b1;
        end else if (!wr_pend_r) begin
          if (cnt_r == ADDR_W'(CELL_COUNT - 1)) begin
            cnt_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_FILL: begin
        if (cnt_r == ADDR_W'(CELL_COUNT - 1)) begin
          cnt_nxt   = '0;
          init_nxt  = 1'b0;
          state_nxt = init_r ? S_IDLE : S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_FILL;
      cnt_r        <= '0;
      wr_pend_r    <= 1'b0;
      init_r       <= 1'b1;
      fill_data_r  <= '0;
      attr_r       <= ATTR_RESET;
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      wr_pend_r    <= wr_pend_nxt;
      init_r       <= init_nxt;
      fill_data_r  <= fill_data_nxt;
      cur_col_r    <= cur_col_nxt;
      cur_row_r    <= cur_row_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_if.valid && cfg_if.ready) attr_r <= cfg_if.text_attribute;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r    <= cnt_r;
    res_scroll_r <= res_scroll_nxt;
    res_data_r   <= res_data_nxt;
    rd_ok_r      <= rd_ok_nxt;
    if (out_load) begin
      out_col_r    <= cur_col_r;
      out_row_r    <= cur_row_r;
      out_pos_r    <= lin_pos(cur_row_r, cur_col_r);
      out_scroll_r <= res_scroll_r;
      out_data_r   <= res_data_r;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.cursor_column   = out_col_r;
  assign out_if.cursor_row      = out_row_r;
  assign out_if.cursor_position = out_pos_r;
  assign out_if.scrolled        = out_scroll_r;
  assign out_if.cell_data       = out_data_r;

  `TCW_ASSERT_IMP(a_row_in_range, state_r == S_IDLE, cur_row_r < ROW_W'(ROWS))
  `TCW_ASSERT_IMP(a_waddr_in_range, mem_we, mem_waddr < ADDR_W'(CELL_COUNT))
  `TCW_ASSERT_NXT(a_result_from_done, out_load, out_valid_r && state_r == S_IDLE)

endmodule

// ===== hw/rtl/tcw_cursor.sv =====
// cursor update for one put-character byte: control codes, wrap and scroll detect
// depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_cursor import tcw_pkg::*; (
  input  logic [COL_W-1:0] col,
  input  logic [ROW_W-1:0] row,
  input  logic [7:0]       char_code,
  output cur_upd_t         upd
);

  logic [COL_W:0] col_w;
  logic [ROW_W:0] row_w;
  logic           wr;

  always_comb begin
    col_w = {1'b0, col};
    row_w = {1'b0, row};
    wr    = 1'b0;
    case (char_code)
      CH_BS: begin
        if (col != '0) col_w = col_w - 1'b1;
      end
      CH_TAB: begin
        col_w = col_w - (col_w % (COL_W+1)'(TAB_STOP)) + (COL_W+1)'(TAB_STOP);
      end
      CH_CR: begin
        col_w = '0;
      end
      CH_LF: begin
        col_w = '0;
        row_w = row_w + 1'b1;
      end
      default: begin
        if (char_code >= CH_BLANK) begin
          wr    = 1'b1;
          col_w = col_w + 1'b1;
        end
      end
    endcase
    // wrap past the last column
    if (col_w > (COL_W+1)'(COLUMNS - 1)) begin
      col_w = '0;
      row_w = row_w + 1'b1;
    end
    upd.scroll = 1'b0;
    if (row_w >= (ROW_W+1)'(ROWS)) begin
      upd.scroll = 1'b1;
      row_w      = (ROW_W+1)'(ROWS - 1);
    end
    upd.col = col_w[COL_W-1:0];
    upd.row = row_w[ROW_W-1:0];
    upd.wr  = wr;
  end

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for the text console character writer
// drives put, clear, read and unused-action items under several stall patterns and attribute
// settings; depends on tcw_pkg, tcw_if and text_console_char_writer
`timescale 1ns / 1ps

module tb;
  import tcw_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int PHASE_ITEMS    = 406;
  localparam int DIRECTED_ROWS  = 26;
  localparam int PRINT_CAP      = 100;

  typedef struct packed {
    action_t           action;
    logic [7:0]        char_code;
    logic [ADDR_W-1:0] cell_index;
  } console_item_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] pos;
    logic              scrolled;
    logic [CELL_W-1:0] cell_data;
  } console_result_t;

  typedef struct packed {
    console_item_t   item;
    bit              typed;
    console_result_t res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  tcw_in_if  in_ch ();
  tcw_out_if out_ch ();
  tcw_cfg_if cfg_ch ();

  text_console_char_writer u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // shadow copy of the screen, cursor and attribute
  logic [CELL_W-1:0] shadow_cells [0:CELL_COUNT-1];
  int                cur_col;
  int                cur_row;
  logic [7:0]        attr_shadow;

  console_result_t cursor_reports_q [$];
  console_item_t   plan_q [$];
  int              mismatch_count;
  int              send_idle_pct;
  int              recv_stall_pct;
  int              idle_cycles;

  // attribute 7 throughout the directed rows
  dir_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{ACT_READ,  8'h00,  11'd0},    1'b1, '{7'd0, 5'd0, 11'd0,   1'b0, 16'h0000}},
    '{'{ACT_READ,  8'h00,  11'd2047}, 1'b1, '{7'd0, 5'd0, 11'd0,   1'b0, 16'h0000}},
    '{'{ACT_PUT,   8'h41,  11'd0},    1'b1, '{7'd1, 5'd0, 11'd1,   1'b0, 16'h0000}},
    '{'{ACT_READ,  8'h00,  11'd0},    1'b1, '{7'd1, 5'd0, 11'd1,   1'b0, 16'h0741}},
    '{'{ACT_PUT,   CH_BS,  11'd0},    1'b1, '{7'd0, 5'd0, 11'd0,   1'b0, 16'h0000}},
    '{'{ACT_PUT,   CH_BS,  11'd0},    1'b1, '{7'd0, 5'd0, 11'd0,   1'b0, 16'h0000}},
    '{'{ACT_PUT,   8'h00,  11'd0},    1'b1, '{7'd0, 5'd0, 11'd0,   1'b0, 16'h0000}},
    '{'{ACT_PUT,   CH_TAB, 11'd0},    1'b1, '{7'd8, 5'd0, 11'd8,   1'b0, 16'h0000}},
    '{'{ACT_PUT,   8'hFF,  11'd0},    1'b1, '{7'd9, 5'd0, 11'd9,   1'b0, 16'h0000}},
    '{'{ACT_PUT,   CH_CR,  11'd0},    1'b1, '{7'd0, 5'd0, 11'd0,   1'b0, 16'h0000}},
    '{'{ACT_PUT,   CH_LF,  11'd0},    1'b1, '{7'd0, 5'd1, 11'd80,  1'b0, 16'h0000}},
    '{'{ACT_PUT,   8'h20,  11'd0},    1'b1, '{7'd1, 5'd1, 11'd81,  1'b0, 16'h0000}},
    '{'{ACT_NONE,  8'hFF,  11'd2047}, 1'b1, '{7'd1, 5'd1, 11'd81,  1'b0, 16'h0000}},
    '{'{ACT_READ,  8'h00,  11'd80},   1'b1, '{7'd1, 5'd1, 11'd81,  1'b0, 16'h0720}},
    '{'{ACT_CLEAR, 8'h00,  11'd0},    1'b1, '{7'd1, 5'd1, 11'd81,  1'b0, 16'h0000}},
    '{'{ACT_READ,  8'h00,  11'd1999}, 1'b1, '{7'd1, 5'd1, 11'd81,  1'b0, 16'h0720}},
    '{'{ACT_PUT,   CH_TAB, 11'd0},    1'b0, '0},
    '{'{ACT_PUT,   CH_TAB, 11'd0},    1'b0, '0},
    '{'{ACT_PUT,   CH_TAB, 11'd0},    1'b0, '0},
    '{'{ACT_PUT,   CH_TAB, 11'd0},    1'b0, '0},
    '{'{ACT_PUT,   CH_TAB, 11'd0},    1'b0, '0},
    '{'{ACT_PUT,   CH_TAB, 11'd0},    1'b0, '0},
    '{'{ACT_PUT,   CH_TAB, 11'd0},    1'b0, '0},
    '{'{ACT_PUT,   CH_TAB, 11'd0},    1'b0, '0},
    '{'{ACT_PUT,   CH_TAB, 11'd0},    1'b0, '0},
    '{'{ACT_PUT,   CH_TAB, 11'd0},    1'b1, '{7'd0, 5'd2, 11'd160, 1'b0, 16'h0000}}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic console_item_t make_item(action_t act, logic [7:0] ch,
                                              logic [ADDR_W-1:0] idx);
    console_item_t it;
    it.action     = act;
    it.char_code  = ch;
    it.cell_index = idx;
    return it;
  endfunction

  // applies one item to the shadow state and returns the cursor report
  function automatic console_result_t console_apply(console_item_t it);
    console_result_t   r;
    logic [CELL_W-1:0] blank;
    r     = '0;
    blank = {attr_shadow, CH_BLANK};
    case (it.action)
      ACT_PUT: begin
        if (it.char_code == CH_BS) begin
          if (cur_col != 0) cur_col--;
        end else if (it.char_code == CH_TAB) begin
          cur_col = cur_col - (cur_col % TAB_STOP) + TAB_STOP;
        end else if (it.char_code == CH_CR) begin
          cur_col = 0;
        end else if (it.char_code == CH_LF) begin
          cur_col = 0;
          cur_row++;
        end else if (it.char_code >= CH_BLANK) begin
          shadow_cells[cur_row * COLUMNS + cur_col] = {attr_shadow, it.char_code};
          cur_col++;
        end
        if (cur_col > COLUMNS - 1) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          for (int i = 0; i < COPY_END; i++) shadow_cells[i] = shadow_cells[i + COLUMNS];
          for (int i = COPY_END; i < CELL_COUNT; i++) shadow_cells[i] = blank;
          cur_row    = ROWS - 1;
          r.scrolled = 1'b1;
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++) shadow_cells[i] = blank;
      end
      ACT_READ: begin
        if (it.cell_index < CELL_COUNT) r.cell_data = shadow_cells[it.cell_index];
      end
      default: ;
    endcase
    r.col = COL_W'(cur_col);
    r.row = ROW_W'(cur_row);
    r.pos = ADDR_W'(cur_row * COLUMNS + cur_col);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_item(console_item_t it, bit typed, console_result_t typed_res);
    console_result_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= it.action;
    in_ch.char_code  <= it.char_code;
    in_ch.cell_index <= it.cell_index;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = console_apply(it);
    cursor_reports_q.push_back(typed ? typed_res : r);
  endtask

  task automatic write_attribute(logic [7:0] value);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.text_attribute <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    attr_shadow = value;
  endtask

  task automatic wait_for_results;
    while (cursor_reports_q.size() != 0) @(posedge clk);
  endtask

  // mostly lines of text ending in cr/lf, with reads, control bytes and noise
  task automatic plan_sequence;
    int kind;
    int len;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      len = $urandom_range(1, 60);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0)
          plan_q.push_back(make_item(ACT_PUT, ($urandom_range(0, 1) ? CH_TAB : CH_BS), '0));
        else
          plan_q.push_back(make_item(ACT_PUT, 8'($urandom_range(32, 255)),
                                     ADDR_W'($urandom)));
      end
      if ($urandom_range(0, 9) < 7) begin
        plan_q.push_back(make_item(ACT_PUT, CH_CR, '0));
        plan_q.push_back(make_item(ACT_PUT, CH_LF, '0));
      end else if ($urandom_range(0, 1)) begin
        plan_q.push_back(make_item(ACT_PUT, CH_LF, '0));
      end
    end else if (kind < 75) begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 1))
          plan_q.push_back(make_item(ACT_READ, 8'($urandom),
                           ADDR_W'(cur_row * COLUMNS + $urandom_range(0, COLUMNS - 1))));
        else
          plan_q.push_back(make_item(ACT_READ, 8'($urandom),
                                     ADDR_W'($urandom_range(0, 2047))));
      end
    end else if (kind < 85) begin
      plan_q.push_back(make_item(ACT_PUT, 8'($urandom_range(0, 31)), ADDR_W'($urandom)));
    end else if (kind < 92) begin
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) plan_q.push_back(make_item(ACT_PUT, CH_BS, '0));
    end else if (kind < 98) begin
      plan_q.push_back(make_item(action_t'($urandom_range(0, 3)), 8'($urandom),
                                 ADDR_W'($urandom)));
    end else begin
      plan_q.push_back(make_item(ACT_CLEAR, 8'($urandom), ADDR_W'($urandom)));
    end
  endtask

  always @(posedge clk) begin
    if (recv_stall_pct != 0)
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    else
      out_ch.ready <= 1'b1;
  end

  always @(posedge clk) begin : result_check
    console_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (cursor_reports_q.size() == 0) begin
        report_mismatch("result with nothing expected", out_ch.cursor_position, 0);
      end else begin
        want = cursor_reports_q.pop_front();
        if (out_ch.cursor_column !== want.col)
          report_mismatch("cursor_column", out_ch.cursor_column, want.col);
        if (out_ch.cursor_row !== want.row)
          report_mismatch("cursor_row", out_ch.cursor_row, want.row);
        if (out_ch.cursor_position !== want.pos)
          report_mismatch("cursor_position", out_ch.cursor_position, want.pos);
        if (out_ch.scrolled !== want.scrolled)
          report_mismatch("scrolled", out_ch.scrolled, want.scrolled);
        if (out_ch.cell_data !== want.cell_data)
          report_mismatch("cell_data", out_ch.cell_data, want.cell_data);
      end
    end
  end

  // counts cycles without any transfer on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0] phase_attr;
    int         sent;
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.action          = ACT_PUT;
    in_ch.char_code       = '0;
    in_ch.cell_index      = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.text_attribute = '0;
    out_ch.ready          = 1'b0;
    mismatch_count        = 0;
    idle_cycles           = 0;
    send_idle_pct         = 0;
    recv_stall_pct        = 0;
    cur_col               = 0;
    cur_row               = 0;
    attr_shadow           = ATTR_RESET;
    for (int i = 0; i < CELL_COUNT; i++) shadow_cells[i] = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].res);
    in_ch.valid <= 1'b0;
    wait_for_results();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          phase_attr     = 8'hFF;
        end
        1: begin
          send_idle_pct  = 71;
          recv_stall_pct = 0;
          phase_attr     = 8'h00;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 71;
          phase_attr     = 8'($urandom_range(1, 254));
        end
        default: begin
          send_idle_pct  = 29;
          recv_stall_pct = 29;
          phase_attr     = 8'($urandom_range(1, 254));
        end
      endcase
      write_attribute(phase_attr);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (plan_q.size() == 0) plan_sequence();
        send_item(plan_q.pop_front(), 1'b0, '0);
        sent++;
      end
      in_ch.valid <= 1'b0;
      wait_for_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && cursor_reports_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_if.sv
hw/rtl/tcw_cursor.sv
hw/rtl/text_console_char_writer.sv
verif/tb.sv
